FILE: rtl/core/assert_macros.svh
// Assertion helpers for the RTL. Both need i_clk in scope, the first also i_rst_n.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define FPCG_ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("fpcg: implication failed");

// Next-cycle implication, checked during reset as well.
`define FPCG_ASSERT_NXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) (ante) |=> (cons)) \
        else $error("fpcg: next-cycle implication failed");

`endif

FILE: rtl/core/fpcg_pkg.sv
`timescale 1ns / 1ps

package fpcg_pkg;

    // Register indexes on the configuration port.
    localparam logic [1:0] REG_MODE      = 2'd0;
    localparam logic [1:0] REG_AMPLITUDE = 2'd1;
    localparam logic [1:0] REG_PERIOD    = 2'd2;
    localparam logic [1:0] REG_PHASE     = 2'd3;

    // Pattern modes.
    localparam logic [1:0] MODE_SINE   = 2'd0;
    localparam logic [1:0] MODE_BINARY = 2'd1;
    localparam logic [1:0] MODE_THREE  = 2'd2;

    // Fixed-point constants of the cosine evaluation.
    localparam logic [30:0] ONE_Q30    = 31'h4000_0000;
    localparam logic [31:0] TWO_PI_Q29 = 32'd3373259426;
    localparam int          POLY_TERMS = 5;

    // Divisors of the nested Taylor evaluation, innermost term first.
    localparam int COS_DIV [POLY_TERMS] = '{90, 56, 30, 12, 2};
    localparam int SIN_DIV [POLY_TERMS] = '{110, 72, 42, 20, 6};

    // Control that travels with a sample through the cosine lane.
    typedef struct packed {
        logic valid;
        logic is_sin;
        logic neg;
    } t_poly_ctl;

endpackage

FILE: rtl/core/fpcg_div_cell.sv
`timescale 1ns / 1ps

// One step of a restoring divider: brings in one dividend bit, emits one quotient bit.
module fpcg_div_cell #(
    parameter int NUM_W = 27,
    parameter int QUO_W = 16
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_en,
    input  logic             i_valid,
    input  logic [NUM_W-1:0] i_num,
    input  logic [11:0]      i_rem,
    input  logic [QUO_W-1:0] i_quo,
    input  logic [11:0]      i_div,
    output logic             o_valid,
    output logic [NUM_W-1:0] o_num,
    output logic [11:0]      o_rem,
    output logic [QUO_W-1:0] o_quo
);

    logic [12:0] w_trial;
    logic        w_ge;
    logic [12:0] w_diff;

    // Trial subtraction of the divisor from the shifted remainder.
    assign w_trial = {i_rem, i_num[NUM_W-1]};
    assign w_ge    = (w_trial >= {1'b0, i_div});
    assign w_diff  = w_trial - {1'b0, i_div};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_valid <= 1'b0;
        end else if (i_en) begin
            o_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            o_num <= {i_num[NUM_W-2:0], 1'b0};
            o_rem <= w_ge ? w_diff[11:0] : w_trial[11:0];
            o_quo <= {i_quo[QUO_W-2:0], w_ge};
        end
    end

endmodule

FILE: rtl/core/fpcg_poly_cell.sv
`timescale 1ns / 1ps

// One term of the nested series: v' = 1 - ((x2 * v) >> 30) / d, over three stages.
module fpcg_poly_cell #(
    parameter int DIV_COS = 90,
    parameter int DIV_SIN = 110
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_en,
    input  fpcg_pkg::t_poly_ctl  i_ctl,
    input  logic [29:0]          i_x2,
    input  logic [29:0]          i_t,
    input  logic [30:0]          i_v,
    output fpcg_pkg::t_poly_ctl  o_ctl,
    output logic [29:0]          o_x2,
    output logic [29:0]          o_t,
    output logic [30:0]          o_v
);

    localparam logic [31:0] M_COS = 32'((64'd1 << 32) / DIV_COS);
    localparam logic [31:0] M_SIN = 32'((64'd1 << 32) / DIV_SIN);
    localparam logic [6:0]  D_COS = 7'(DIV_COS);
    localparam logic [6:0]  D_SIN = 7'(DIV_SIN);

    fpcg_pkg::t_poly_ctl r_a_ctl, r_b_ctl;
    logic [29:0] r_a_x2, r_a_t, r_a_p;
    logic [29:0] r_b_x2, r_b_t, r_b_p, r_b_q0;

    logic [60:0] w_prod;
    logic [31:0] w_m;
    logic [61:0] w_pm;
    logic [6:0]  w_d;
    logic [36:0] w_qd;
    logic [29:0] w_rem;
    logic [29:0] w_q;

    // Stage A: product with the squared angle.
    assign w_prod = i_x2 * i_v;

    // Stage B: estimate of the quotient by the reciprocal, low by at most one.
    assign w_m  = r_a_ctl.is_sin ? M_SIN : M_COS;
    assign w_pm = r_a_p * w_m;

    // Stage C: one correction step, then subtract from one.
    assign w_d   = r_b_ctl.is_sin ? D_SIN : D_COS;
    assign w_qd  = r_b_q0 * w_d;
    assign w_rem = r_b_p - w_qd[29:0];
    assign w_q   = r_b_q0 + 30'(w_rem >= 30'(w_d));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_ctl <= '0;
            r_b_ctl <= '0;
            o_ctl   <= '0;
        end else if (i_en) begin
            r_a_ctl <= i_ctl;
            r_b_ctl <= r_a_ctl;
            o_ctl   <= r_b_ctl;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_a_x2 <= i_x2;
            r_a_t  <= i_t;
            r_a_p  <= w_prod[59:30];
            r_b_x2 <= r_a_x2;
            r_b_t  <= r_a_t;
            r_b_p  <= r_a_p;
            r_b_q0 <= w_pm[61:32];
            o_x2   <= r_b_x2;
            o_t    <= r_b_t;
            o_v    <= fpcg_pkg::ONE_Q30 - {1'b0, w_q};
        end
    end

endmodule

FILE: rtl/core/fpcg_cos_lane.sv
`timescale 1ns / 1ps

// Cosine of a turn fraction as a signed Q14 value, pipelined.
module fpcg_cos_lane #(
    parameter int ANGLE_BITS = 16
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_en,
    input  logic                    i_valid,
    input  logic [ANGLE_BITS-1:0]   i_angle,
    output logic                    o_valid,
    output logic signed [15:0]      o_cos
);

    localparam int NT = fpcg_pkg::POLY_TERMS;

    fpcg_pkg::t_poly_ctl r_s0_ctl, r_s1_ctl, r_s2_ctl, r_f1_ctl;
    logic [29:0] r_s0_u, r_s1_t, r_s2_t, r_s2_x2;
    logic [30:0] r_f1_mag;

    logic [31:0] w_a, w_a1, w_a2, w_u;
    logic        w_neg, w_sin;
    logic [61:0] w_rad;
    logic [59:0] w_sq;
    logic [60:0] w_tv;
    logic [31:0] w_rnd;
    logic [15:0] w_q;

    fpcg_pkg::t_poly_ctl w_pc  [NT+1];
    logic [29:0]         w_px2 [NT+1];
    logic [29:0]         w_pt  [NT+1];
    logic [30:0]         w_pv  [NT+1];

    // Fold the angle into the first octant, noting sign and sine use.
    assign w_a   = {i_angle, {(32-ANGLE_BITS){1'b0}}};
    assign w_a1  = (w_a > 32'h8000_0000) ? (32'd0 - w_a) : w_a;
    assign w_neg = (w_a1 > 32'h4000_0000);
    assign w_a2  = w_neg ? (32'h8000_0000 - w_a1) : w_a1;
    assign w_sin = (w_a2 > 32'h2000_0000);
    assign w_u   = w_sin ? (32'h4000_0000 - w_a2) : w_a2;

    // Turn fraction to radians, then the squared angle.
    assign w_rad = r_s0_u * fpcg_pkg::TWO_PI_Q29;
    assign w_sq  = r_s1_t * r_s1_t;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s0_ctl <= '0;
            r_s1_ctl <= '0;
            r_s2_ctl <= '0;
        end else if (i_en) begin
            r_s0_ctl <= '{valid: i_valid, is_sin: w_sin, neg: w_neg};
            r_s1_ctl <= r_s0_ctl;
            r_s2_ctl <= r_s1_ctl;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_s0_u  <= w_u[29:0];
            r_s1_t  <= w_rad[60:31];
            r_s2_t  <= r_s1_t;
            r_s2_x2 <= w_sq[59:30];
        end
    end

    // Chain of series terms.
    assign w_pc[0]  = r_s2_ctl;
    assign w_px2[0] = r_s2_x2;
    assign w_pt[0]  = r_s2_t;
    assign w_pv[0]  = fpcg_pkg::ONE_Q30;

    for (genvar gi = 0; gi < NT; gi++) begin : g_term
        fpcg_poly_cell #(
            .DIV_COS (fpcg_pkg::COS_DIV[gi]),
            .DIV_SIN (fpcg_pkg::SIN_DIV[gi])
        ) u_term (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (i_en),
            .i_ctl   (w_pc[gi]),
            .i_x2    (w_px2[gi]),
            .i_t     (w_pt[gi]),
            .i_v     (w_pv[gi]),
            .o_ctl   (w_pc[gi+1]),
            .o_x2    (w_px2[gi+1]),
            .o_t     (w_pt[gi+1]),
            .o_v     (w_pv[gi+1])
        );
    end

    // Sine needs the final multiply by the angle; then round to Q14 and apply sign.
    assign w_tv  = w_pt[NT] * w_pv[NT];
    assign w_rnd = {1'b0, r_f1_mag} + 32'd32768;
    assign w_q   = w_rnd[31:16];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_f1_ctl <= '0;
            o_valid  <= 1'b0;
        end else if (i_en) begin
            r_f1_ctl <= w_pc[NT];
            o_valid  <= r_f1_ctl.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_f1_mag <= w_pc[NT].is_sin ? w_tv[60:30] : w_pv[NT];
            o_cos    <= r_f1_ctl.neg ? $signed(16'd0 - w_q) : $signed(w_q);
        end
    end

endmodule

FILE: rtl/core/fringe_pattern_column_generator.sv
`timescale 1ns / 1ps

// Channel     Direction  Content
// s_axis      in         tdata: column[10:0], zero fill to 16 bits
// m_axis      out        tdata: blue[7:0], green[15:8], red[23:16]
// i_cfg_*     in         write enable, register index, 16-bit data
//
// One column is taken per clock while m_axis does not stall; it crosses 11 + ANGLE_BITS
// restoring divider cells, the angle registers, the cosine lanes and output register.
// All stages advance together whenever the output register is empty or being read,
// so a stall on m_axis holds the whole pipeline and drops s_axis_tready.
// Reset is synchronous and clears the valid flags and loads the register defaults.
`include "assert_macros.svh"

module fringe_pattern_column_generator #(
    parameter int ANGLE_BITS = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [15:0] s_axis_tdata,   // column[10:0], zeros above
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [23:0] m_axis_tdata,   // blue[7:0], green[15:8], red[23:16]
    input  logic        i_cfg_we,
    input  logic [1:0]  i_cfg_addr,
    input  logic [15:0] i_cfg_wdata
);

    localparam int AB    = ANGLE_BITS;
    localparam int NUM_W = 11 + AB;
    localparam logic [AB-1:0] THIRD      = AB'(((64'd1 << AB) + 64'd1) / 3);
    localparam logic [AB-1:0] TWO_THIRDS = AB'(((64'd2 << AB) + 64'd1) / 3);

    logic [1:0]  r_mode;
    logic [7:0]  r_amp;
    logic [11:0] r_period;
    logic [15:0] r_phase;

    logic        w_en;
    logic [11:0] w_div;

    logic             w_dv_valid [NUM_W+1];
    logic [NUM_W-1:0] w_dv_num   [NUM_W+1];
    logic [11:0]      w_dv_rem   [NUM_W+1];
    logic [AB-1:0]    w_dv_quo   [NUM_W+1];

    logic [AB+15:0] w_ph_wide;
    logic [AB-1:0]  w_ang;
    logic           r_ang_valid;
    logic [AB-1:0]  r_ang_b, r_ang_g, r_ang_r;

    logic               w_b_valid, w_g_valid, w_r_valid;
    logic signed [15:0] w_b_cos, w_g_cos, w_r_cos;
    logic [8:0]         w_bin;
    logic [7:0]         w_lvl_b, w_lvl_g, w_lvl_r;

    logic       r_out_valid;
    logic [7:0] r_out_b, r_out_g, r_out_r;

    // Configuration registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode   <= fpcg_pkg::MODE_SINE;
            r_amp    <= 8'd255;
            r_period <= 12'd64;
            r_phase  <= 16'd0;
        end else if (i_cfg_we) begin
            case (i_cfg_addr)
                fpcg_pkg::REG_MODE:      r_mode   <= i_cfg_wdata[1:0];
                fpcg_pkg::REG_AMPLITUDE: r_amp    <= i_cfg_wdata[7:0];
                fpcg_pkg::REG_PERIOD:    r_period <= i_cfg_wdata[11:0];
                fpcg_pkg::REG_PHASE:     r_phase  <= i_cfg_wdata;
                default: ;
            endcase
        end
    end

    // Whole pipeline moves when the output register can take a new transfer.
    assign w_en          = !r_out_valid || m_axis_tready;
    assign s_axis_tready = w_en;

    // Divider chain: (column << AB) / period, low AB quotient bits kept.
    assign w_div         = (r_period == 12'd0) ? 12'd1 : r_period;
    assign w_dv_valid[0] = s_axis_tvalid;
    assign w_dv_num[0]   = {s_axis_tdata[10:0], {AB{1'b0}}};
    assign w_dv_rem[0]   = 12'd0;
    assign w_dv_quo[0]   = '0;

    for (genvar gi = 0; gi < NUM_W; gi++) begin : g_div
        fpcg_div_cell #(
            .NUM_W (NUM_W),
            .QUO_W (AB)
        ) u_div (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (w_en),
            .i_valid (w_dv_valid[gi]),
            .i_num   (w_dv_num[gi]),
            .i_rem   (w_dv_rem[gi]),
            .i_quo   (w_dv_quo[gi]),
            .i_div   (w_div),
            .o_valid (w_dv_valid[gi+1]),
            .o_num   (w_dv_num[gi+1]),
            .o_rem   (w_dv_rem[gi+1]),
            .o_quo   (w_dv_quo[gi+1])
        );
    end

    // Phase scaled from 16 bits to the angle width, then the three channel angles.
    assign w_ph_wide = {r_phase, {AB{1'b0}}};
    assign w_ang     = w_dv_quo[NUM_W] + w_ph_wide[AB+15:16];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ang_valid <= 1'b0;
        end else if (w_en) begin
            r_ang_valid <= w_dv_valid[NUM_W];
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_ang_g <= w_ang;
            r_ang_b <= (r_mode == fpcg_pkg::MODE_THREE) ? w_ang + THIRD : w_ang;
            r_ang_r <= (r_mode == fpcg_pkg::MODE_THREE) ? w_ang + TWO_THIRDS : w_ang;
        end
    end

    fpcg_cos_lane #(.ANGLE_BITS(AB)) u_lane_b (
        .i_clk (i_clk), .i_rst_n (i_rst_n), .i_en (w_en),
        .i_valid (r_ang_valid), .i_angle (r_ang_b),
        .o_valid (w_b_valid), .o_cos (w_b_cos)
    );

    fpcg_cos_lane #(.ANGLE_BITS(AB)) u_lane_g (
        .i_clk (i_clk), .i_rst_n (i_rst_n), .i_en (w_en),
        .i_valid (r_ang_valid), .i_angle (r_ang_g),
        .o_valid (w_g_valid), .o_cos (w_g_cos)
    );

    fpcg_cos_lane #(.ANGLE_BITS(AB)) u_lane_r (
        .i_clk (i_clk), .i_rst_n (i_rst_n), .i_en (w_en),
        .i_valid (r_ang_valid), .i_angle (r_ang_r),
        .o_valid (w_r_valid), .o_cos (w_r_cos)
    );

    // Level = (255 * 16384 + amplitude * cos) >> 15.
    function automatic logic [7:0] fringe_level(input logic [7:0] amp,
                                                input logic signed [15:0] c);
        logic signed [24:0] prod;
        logic signed [24:0] sum;
        begin
            prod = $signed({1'b0, amp}) * c;
            sum  = 25'sd4177920 + prod;
            return sum[22:15];
        end
    endfunction

    assign w_bin   = (w_g_cos > 16'sd0) ? ((9'd255 + {1'b0, r_amp}) >> 1)
                                        : ((9'd255 - {1'b0, r_amp}) >> 1);
    assign w_lvl_b = fringe_level(r_amp, w_b_cos);
    assign w_lvl_g = fringe_level(r_amp, w_g_cos);
    assign w_lvl_r = fringe_level(r_amp, w_r_cos);

    // Output register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_en) begin
            r_out_valid <= w_g_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            if (r_mode == fpcg_pkg::MODE_BINARY) begin
                r_out_b <= w_bin[7:0];
                r_out_g <= w_bin[7:0];
                r_out_r <= w_bin[7:0];
            end else begin
                r_out_b <= w_lvl_b;
                r_out_g <= w_lvl_g;
                r_out_r <= w_lvl_r;
            end
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {r_out_r, r_out_g, r_out_b};

    // The three lanes run in lockstep.
    `FPCG_ASSERT_IMP(a_lanes_aligned, w_g_valid, w_b_valid && w_r_valid && w_b_valid == w_r_valid)
    // A rounded cosine never exceeds one in Q14.
    `FPCG_ASSERT_IMP(a_cos_range, w_g_valid, w_g_cos <= 16'sd16384 && w_g_cos >= -16'sd16384)
    // A new result comes only from a valid lane output.
    `FPCG_ASSERT_IMP(a_out_source, $rose(m_axis_tvalid), $past(w_g_valid))
    // Reset empties the output register.
    `FPCG_ASSERT_NXT(a_reset_clears, !i_rst_n, !m_axis_tvalid)

endmodule

FILE: verif/fringe_pattern_column_generator_tb.sv
`timescale 1ns / 1ps

module fringe_pattern_column_generator_tb;

    localparam logic [1:0] MODE_UNUSED = 2'd3;
    localparam int PIPE_DRAIN = 60;
    localparam int CYCLE_LIMIT = 400000;
    localparam logic [15:0] THIRD_TURN = 16'd21845;
    localparam logic [15:0] TWO_THIRD_TURN = 16'd43691;

    typedef struct packed {
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
    } t_pixel;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [15:0] s_axis_tdata = '0;     // column[10:0], zeros above
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [23:0] m_axis_tdata;          // blue[7:0], green[15:8], red[23:16]
    logic        i_cfg_we = 1'b0;
    logic [1:0]  i_cfg_addr = '0;
    logic [15:0] i_cfg_wdata = '0;

    // Shadow copy of the configuration registers.
    logic [1:0]  cur_mode;
    logic [7:0]  cur_amp;
    logic [11:0] cur_period;
    logic [15:0] cur_phase;

    t_pixel pending_pixels[$];
    int     error_count = 0;
    int     cycle_count = 0;
    bit     sink_no_stall = 1'b0;
    bit     src_no_gap = 1'b0;

    fringe_pattern_column_generator dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
        .s_axis_tdata(s_axis_tdata),
        .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
        .m_axis_tdata(m_axis_tdata),
        .i_cfg_we(i_cfg_we), .i_cfg_addr(i_cfg_addr), .i_cfg_wdata(i_cfg_wdata)
    );

    always #6 i_clk = ~i_clk;

    // Watchdog on the total run length.
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("Simulation FAILED");
            $finish;
        end
    end

    // Nested Taylor series on an octant; t is radians in Q30.
    function automatic longint unsigned octant_series(longint unsigned t, bit want_sin);
        longint unsigned x2;
        longint unsigned v;
        longint unsigned dv;
        x2 = (t * t) >> 30;
        v = 64'd1 << 30;
        for (int i = 0; i < 5; i++) begin
            if (want_sin) dv = (i == 0) ? 110 : (i == 1) ? 72 : (i == 2) ? 42 : (i == 3) ? 20 : 6;
            else          dv = (i == 0) ? 90 : (i == 1) ? 56 : (i == 2) ? 30 : (i == 3) ? 12 : 2;
            v = (64'd1 << 30) - ((x2 * v) >> 30) / dv;
        end
        return want_sin ? ((t * v) >> 30) : v;
    endfunction

    // Cosine of a 16-bit turn fraction, 16384 = 1.0, rounded to nearest.
    function automatic int cosine_q14(logic [15:0] ang);
        logic [31:0]     a;
        bit              neg;
        longint unsigned mag;
        longint unsigned q;
        a = {ang, 16'h0000};
        neg = 1'b0;
        if (a > 32'h8000_0000) a = 32'h0 - a;
        if (a > 32'h4000_0000) begin
            a = 32'h8000_0000 - a;
            neg = 1'b1;
        end
        if (a > 32'h2000_0000)
            mag = octant_series((64'(32'h4000_0000 - a) * 64'd3373259426) >> 31, 1'b1);
        else
            mag = octant_series((64'(a) * 64'd3373259426) >> 31, 1'b0);
        q = (mag + 64'd32768) >> 16;
        return neg ? -int'(q) : int'(q);
    endfunction

    function automatic logic [7:0] fringe_level(logic [15:0] ang);
        longint num;
        num = 255 * 16384 + longint'(cur_amp) * longint'(cosine_q14(ang));
        return num[22:15];
    endfunction

    // Expected pixel for one column under the current configuration.
    function automatic t_pixel column_pixel(logic [10:0] col);
        longint unsigned per;
        logic [15:0]     ang;
        logic [8:0]      bin;
        t_pixel          px;
        per = (cur_period == 0) ? 1 : cur_period;
        ang = 16'(((64'(col) << 16) / per) + cur_phase);
        if (cur_mode == fpcg_pkg::MODE_BINARY) begin
            bin = (cosine_q14(ang) > 0) ? (9'd255 + cur_amp) : (9'd255 - cur_amp);
            px.blue = bin[8:1];
            px.green = bin[8:1];
            px.red = bin[8:1];
        end else if (cur_mode == fpcg_pkg::MODE_THREE) begin
            px.blue = fringe_level(ang + THIRD_TURN);
            px.green = fringe_level(ang);
            px.red = fringe_level(ang + TWO_THIRD_TURN);
        end else begin
            px.blue = fringe_level(ang);
            px.green = px.blue;
            px.red = px.blue;
        end
        return px;
    endfunction

    // Sends one column after a random gap, none if src_no_gap is set, and records its expected pixel.
    task automatic send_column(logic [10:0] col);
        int gap;
        gap = src_no_gap ? 0 : $urandom_range(0, 8);
        if (gap > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata <= {5'b0, col};
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        pending_pixels.push_back(column_pixel(col));
    endtask

    // Stops sending and waits for the pipeline to drain.
    task automatic drain_pipeline();
        s_axis_tvalid <= 1'b0;
        @(posedge i_clk);
        while (pending_pixels.size() != 0) @(posedge i_clk);
        repeat (PIPE_DRAIN) @(posedge i_clk);
    endtask

    // Drives one register write; the caller drops the write enable after the last one.
    task automatic write_reg(logic [1:0] idx, logic [15:0] val);
        i_cfg_we <= 1'b1;
        i_cfg_addr <= idx;
        i_cfg_wdata <= val;
        @(posedge i_clk);
        case (idx)
            fpcg_pkg::REG_MODE:      cur_mode = val[1:0];
            fpcg_pkg::REG_AMPLITUDE: cur_amp = val[7:0];
            fpcg_pkg::REG_PERIOD:    cur_period = val[11:0];
            default:                 cur_phase = val;
        endcase
    endtask

    task automatic set_config(logic [1:0] mode, logic [7:0] amp, logic [11:0] per,
                              logic [15:0] ph);
        drain_pipeline();
        write_reg(fpcg_pkg::REG_MODE, {14'b0, mode});
        write_reg(fpcg_pkg::REG_AMPLITUDE, {8'b0, amp});
        write_reg(fpcg_pkg::REG_PERIOD, {4'b0, per});
        write_reg(fpcg_pkg::REG_PHASE, ph);
        i_cfg_we <= 1'b0;
    endtask

    // Result sink: random stalls unless sink_no_stall is set, each transfer checked against the oldest expectation.
    initial begin : sink
        int     stall;
        t_pixel got;
        t_pixel want;
        @(posedge i_clk);
        while (!i_rst_n) @(posedge i_clk);
        forever begin
            stall = sink_no_stall ? 0 : $urandom_range(0, 8);
            if (stall > 0) begin
                m_axis_tready <= 1'b0;
                repeat (stall) @(posedge i_clk);
            end
            m_axis_tready <= 1'b1;
            @(posedge i_clk);
            while (!m_axis_tvalid) @(posedge i_clk);
            got = m_axis_tdata;
            if (pending_pixels.size() == 0) begin
                $error("unexpected result transfer: %h", got);
                error_count++;
            end else begin
                want = pending_pixels.pop_front();
                if (got.blue !== want.blue) begin
                    $error("blue_level expected %0d actual %0d", want.blue, got.blue);
                    error_count++;
                end
                if (got.green !== want.green) begin
                    $error("green_level expected %0d actual %0d", want.green, got.green);
                    error_count++;
                end
                if (got.red !== want.red) begin
                    $error("red_level expected %0d actual %0d", want.red, got.red);
                    error_count++;
                end
            end
        end
    end

    // Reset defaults, edge columns and a full period.
    task automatic test_reset_defaults();
        send_column(11'd0);
        send_column(11'd2047);
        send_column(11'd1);
        send_column(11'd16);
        send_column(11'd32);
        send_column(11'd48);
    endtask

    // Each mode, the unused mode, and the register extremes.
    task automatic test_directed_modes();
        set_config(fpcg_pkg::MODE_BINARY, 8'd255, 12'd64, 16'd0);
        send_column(11'd0);
        send_column(11'd16);
        send_column(11'd32);
        send_column(11'd1365);
        set_config(fpcg_pkg::MODE_THREE, 8'd200, 12'd2048, 16'hFFFF);
        send_column(11'd0);
        send_column(11'd2047);
        send_column(11'd683);
        set_config(MODE_UNUSED, 8'd0, 12'd0, 16'h4000);
        send_column(11'd5);
        send_column(11'd2047);
        set_config(fpcg_pkg::MODE_SINE, 8'd128, 12'd4095, 16'h8000);
        send_column(11'd2047);
        send_column(11'd1024);
        set_config(fpcg_pkg::MODE_BINARY, 8'd0, 12'd1, 16'h4000);
        send_column(11'd3);
        send_column(11'd1234);
        set_config(fpcg_pkg::MODE_THREE, 8'd255, 12'd3, 16'd1);
        send_column(11'd1);
        send_column(11'd2);
    endtask

    // Random columns over a series of random and extreme configurations.
    task automatic test_random_columns();
        logic [7:0]  amp;
        logic [11:0] per;
        for (int phase_idx = 0; phase_idx < 16; phase_idx++) begin
            amp = (phase_idx % 4 == 0) ? 8'd255 : (phase_idx % 4 == 1) ? 8'd0 : 8'($urandom);
            per = (phase_idx % 5 == 0) ? 12'($urandom) : 12'($urandom_range(1, 2048));
            set_config(2'($urandom), amp, per, 16'($urandom));
            sink_no_stall = (phase_idx % 6 == 2);
            src_no_gap = (phase_idx % 6 == 2) || (phase_idx % 7 == 4);
            for (int n = 0; n < 50; n++) begin
                send_column(11'($urandom));
                // Occasional full drain with the source held off.
                if ($urandom_range(0, 40) == 0) drain_pipeline();
            end
        end
        sink_no_stall = 1'b0;
        src_no_gap = 1'b0;
    endtask

    initial begin
        cur_mode = fpcg_pkg::MODE_SINE;
        cur_amp = 8'd255;
        cur_period = 12'd64;
        cur_phase = 16'd0;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_reset_defaults();
        test_directed_modes();
        test_random_columns();
        drain_pipeline();
        if (error_count == 0 && pending_pixels.size() == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule
